// ===== design/path_canonicalizer_top_defines.svh =====
`ifndef PATH_CANONICALIZER_TOP_DEFINES_SVH
`define PATH_CANONICALIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path_canonicalizer_top: port check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define PC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path_canonicalizer_top: port check failed");

`endif

// ===== design/pcanon_pkg.sv =====
`timescale 1ns / 1ps

package pcanon_pkg;

  localparam logic [7:0] SLASH_BYTE = 8'd47;
  localparam logic [7:0] DOT_BYTE   = 8'd46;

  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_DOT    = 2'd1;
  localparam logic [1:0] CLS_DOTDOT = 2'd2;
  localparam logic [1:0] CLS_OTHER  = 2'd3;

  localparam int SEG_LEN_W = 7;
  localparam logic [SEG_LEN_W-1:0] SEG_LEN_SAT = 7'd127;

  typedef struct packed {
    logic take;
    logic close;
    logic drain;
    logic fire;
    logic clear;
  } pcanon_cmd_t;

  typedef struct packed {
    logic out_last;
  } pcanon_sts_t;

endpackage

// ===== design/pcanon_ctrl.sv =====
`timescale 1ns / 1ps

module pcanon_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tlast,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output pcanon_pkg::pcanon_cmd_t  cmd,
  input  pcanon_pkg::pcanon_sts_t  sts
);
  import pcanon_pkg::*;

  localparam logic [1:0] ST_IN    = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;
  logic       fire;
  logic       done;

  assign s_tready = (state == ST_IN);
  assign m_tvalid = (state == ST_DRAIN);
  assign take     = s_tvalid && s_tready;
  assign fire     = m_tvalid && m_tready;
  assign done     = fire && sts.out_last;

  assign cmd.take  = take;
  assign cmd.close = (state == ST_CLOSE);
  assign cmd.drain = (state == ST_DRAIN);
  assign cmd.fire  = fire;
  assign cmd.clear = done;

  always_comb begin
    state_next = state;
    case (state)
      ST_IN: begin
        if (take && s_tlast) state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = ST_IN;
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/pcanon_dp.sv =====
`timescale 1ns / 1ps

module pcanon_dp #(
  parameter int MAX_PATH_BYTES = 64,
  parameter int MAX_SEGMENTS   = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pcanon_pkg::pcanon_cmd_t  cmd,
  input  logic [7:0]               ch,
  output pcanon_pkg::pcanon_sts_t  sts,
  output logic [7:0]               out_ch,
  output logic                     out_last,
  output logic                     overflow
);
  import pcanon_pkg::*;

  localparam int LW         = $clog2(MAX_PATH_BYTES + 1);
  localparam int SW         = $clog2(MAX_SEGMENTS + 1);
  localparam int SIW        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int BANK_DEPTH = (MAX_PATH_BYTES + 1) / 2;
  localparam int BW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int SUMW       = SEG_LEN_W + 1;
  localparam logic [LW-1:0]   MAX_LEN = LW'(MAX_PATH_BYTES);
  localparam logic [SW-1:0]   MAX_SEG = SW'(MAX_SEGMENTS);
  localparam logic [SUMW-1:0] MAX_SUM = SUMW'(MAX_PATH_BYTES);

  // path bytes split into even and odd banks so a slash and the
  // first segment byte can be written in the same cycle
  logic [7:0]    bank0 [BANK_DEPTH];
  logic [7:0]    bank1 [BANK_DEPTH];
  logic [LW-1:0] segment_starts [MAX_SEGMENTS];

  logic [SW-1:0]        stack_count,      stack_count_next;
  logic [LW-1:0]        committed_length, committed_length_next;
  logic [LW-1:0]        working_length,   working_length_next;
  logic [SEG_LEN_W-1:0] segment_length,   segment_length_next;
  logic [1:0]           segment_class,    segment_class_next;
  logic                 overflow_flag,    overflow_flag_next;

  logic            close_now;
  logic [LW-1:0]   commit_tmp;
  logic [LW-1:0]   wl_tmp;
  logic [SUMW-1:0] seg_sum;
  logic [SIW-1:0]  top_idx;
  logic [LW-1:0]   top_start;
  logic [SIW-1:0]  push_idx;
  logic            push_en;
  logic            wa_en;
  logic [LW-1:0]   wa_addr;
  logic            wb_en;
  logic [LW-1:0]   wb_addr;
  logic            b0_we;
  logic [BW-1:0]   b0_addr;
  logic [7:0]      b0_data;
  logic            b1_we;
  logic [BW-1:0]   b1_addr;
  logic [7:0]      b1_data;

  logic [LW-1:0]   idx;
  logic [LW-1:0]   rd_addr;
  logic [7:0]      rd0;
  logic [7:0]      rd1;
  logic            rd_sel;
  logic            last_i;

  assign close_now = cmd.close || (cmd.take && (ch == SLASH_BYTE));
  assign top_idx   = SIW'(stack_count_next - 1'b1);
  assign push_idx  = SIW'(stack_count);
  assign seg_sum   = SUMW'(committed_length) + SUMW'(1) + SUMW'(segment_length);

  always_comb begin
    stack_count_next      = stack_count;
    committed_length_next = committed_length;
    working_length_next   = working_length;
    segment_length_next   = segment_length;
    segment_class_next    = segment_class;
    overflow_flag_next    = overflow_flag;
    commit_tmp            = committed_length;
    wl_tmp                = working_length;
    push_en               = 1'b0;
    wa_en                 = 1'b0;
    wa_addr               = working_length;
    wb_en                 = 1'b0;
    wb_addr               = working_length;
    if (cmd.clear) begin
      stack_count_next      = '0;
      committed_length_next = '0;
      working_length_next   = '0;
      segment_length_next   = '0;
      segment_class_next    = CLS_EMPTY;
      overflow_flag_next    = 1'b0;
    end else if (close_now) begin
      case (segment_class)
        CLS_DOTDOT: begin
          if (stack_count != '0) begin
            stack_count_next = stack_count - 1'b1;
            commit_tmp       = top_start;
          end
        end
        CLS_OTHER: begin
          if (committed_length >= MAX_LEN || stack_count >= MAX_SEG) begin
            overflow_flag_next = 1'b1;
          end else begin
            if (seg_sum > MAX_SUM) overflow_flag_next = 1'b1;
            push_en          = 1'b1;
            stack_count_next = stack_count + 1'b1;
            commit_tmp       = working_length;
          end
        end
        default: begin
        end
      endcase
      committed_length_next = commit_tmp;
      working_length_next   = commit_tmp;
      segment_length_next   = '0;
      segment_class_next    = CLS_EMPTY;
    end else if (cmd.take) begin
      if (segment_length == '0) begin
        if (wl_tmp < MAX_LEN) begin
          wa_en   = 1'b1;
          wa_addr = wl_tmp;
          wl_tmp  = wl_tmp + 1'b1;
        end
        segment_class_next = (ch == DOT_BYTE) ? CLS_DOT : CLS_OTHER;
      end else if (segment_class == CLS_DOT && ch == DOT_BYTE) begin
        segment_class_next = CLS_DOTDOT;
      end else begin
        segment_class_next = CLS_OTHER;
      end
      if (wl_tmp < MAX_LEN) begin
        wb_en   = 1'b1;
        wb_addr = wl_tmp;
        wl_tmp  = wl_tmp + 1'b1;
      end
      working_length_next = wl_tmp;
      if (segment_length != SEG_LEN_SAT) segment_length_next = segment_length + 1'b1;
    end
  end

  always_comb begin
    b0_we   = 1'b0;
    b0_addr = BW'(wb_addr >> 1);
    b0_data = ch;
    b1_we   = 1'b0;
    b1_addr = BW'(wb_addr >> 1);
    b1_data = ch;
    if (wa_en && !wa_addr[0]) begin
      b0_we   = 1'b1;
      b0_addr = BW'(wa_addr >> 1);
      b0_data = SLASH_BYTE;
    end else if (wb_en && !wb_addr[0]) begin
      b0_we = 1'b1;
    end
    if (wa_en && wa_addr[0]) begin
      b1_we   = 1'b1;
      b1_addr = BW'(wa_addr >> 1);
      b1_data = SLASH_BYTE;
    end else if (wb_en && wb_addr[0]) begin
      b1_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count      <= '0;
      committed_length <= '0;
      working_length   <= '0;
      segment_length   <= '0;
      segment_class    <= CLS_EMPTY;
      overflow_flag    <= 1'b0;
    end else begin
      stack_count      <= stack_count_next;
      committed_length <= committed_length_next;
      working_length   <= working_length_next;
      segment_length   <= segment_length_next;
      segment_class    <= segment_class_next;
      overflow_flag    <= overflow_flag_next;
    end
  end

  // top_start tracks the entry on top of the stack
  always_ff @(posedge clk) begin
    if (push_en) segment_starts[push_idx] <= committed_length;
    top_start <= push_en ? committed_length : segment_starts[top_idx];
  end

  always_ff @(posedge clk) begin
    if (b0_we) bank0[b0_addr] <= b0_data;
    if (b1_we) bank1[b1_addr] <= b1_data;
    rd0    <= bank0[BW'(rd_addr >> 1)];
    rd1    <= bank1[BW'(rd_addr >> 1)];
    rd_sel <= rd_addr[0];
  end

  // read runs one byte ahead of the presented one
  assign last_i = (committed_length == '0) || ((idx + 1'b1) == committed_length);

  always_comb begin
    rd_addr = '0;
    if (cmd.drain) begin
      rd_addr = (cmd.fire && !last_i) ? idx + 1'b1 : idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.close) begin
      idx <= '0;
    end else if (cmd.fire) begin
      idx <= idx + 1'b1;
    end
  end

  assign out_ch       = (committed_length == '0) ? SLASH_BYTE : (rd_sel ? rd1 : rd0);
  assign out_last     = last_i;
  assign overflow     = overflow_flag;
  assign sts.out_last = last_i;

endmodule

// ===== design/path_canonicalizer_top.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata              tuser       tlast
// s_*      in   [7:0] ch           -           last
// m_*      out  [7:0] out_ch       [0] overflow out_last
//
// One path byte is taken per cycle while no result is pending.
// After the byte marked last, the close state ends the final segment, then
// one result per cycle from the banked path buffer (read one byte ahead).
// m_tready low holds the current byte; s_tready stays low until the last
// result transaction. rst clears state and registers, not the buffers.
module path_canonicalizer_top #(
  parameter int MAX_PATH_BYTES = 64,
  parameter int MAX_SEGMENTS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] ch
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] out_ch
  output logic       m_tlast,
  output logic       m_tuser   // [0] overflow
);
  import pcanon_pkg::*;

  pcanon_cmd_t cmd;
  pcanon_sts_t sts;

  pcanon_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pcanon_dp #(
    .MAX_PATH_BYTES (MAX_PATH_BYTES),
    .MAX_SEGMENTS   (MAX_SEGMENTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ch       (s_tdata),
    .sts      (sts),
    .out_ch   (m_tdata),
    .out_last (m_tlast),
    .overflow (m_tuser)
  );

endmodule

// ===== design/pcanon_checker.sv =====
`timescale 1ns / 1ps
`include "path_canonicalizer_top_defines.svh"

module pcanon_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  `PC_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready)
  `PC_ASSERT_NEXT(a_last_starts_drain, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid ##1 m_tvalid)
  `PC_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
  `PC_ASSERT_NEXT(a_flag_steady, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser)))
  `PC_ASSERT_NEXT(a_reopen_input, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

endmodule

bind path_canonicalizer_top pcanon_checker u_pcanon_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
